[rtl/core/bunt_pkg.sv]
// Package for the decision-diagram unique node table.
// Field widths, operation codes and the bucket hash; no dependencies.
package bunt_pkg;

    localparam int FUNC_W  = 1;
    localparam int VAR_W   = 10;
    localparam int CHILD_W = 16;
    localparam int INDEX_W = 16;
    localparam int HASH_W  = 18;

    localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 1'b1;

    // Full bucket sum before reduction; it never exceeds 18 bits.
    function automatic logic [HASH_W-1:0] bunt_hash(
        input logic [VAR_W-1:0]   var_index,
        input logic [CHILD_W-1:0] high_child,
        input logic [CHILD_W-1:0] low_child
    );
        logic [HASH_W-1:0] sum;
        sum = HASH_W'(var_index) + {1'b0, high_child, 1'b0} + HASH_W'(low_child[CHILD_W-1:2]);
        return sum;
    endfunction

endpackage

[rtl/core/bunt_req_if.sv]
// Request channel of the unique node table: valid, ready and one request item.
// Depends on bunt_pkg for the field widths.
interface bunt_req_if import bunt_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [FUNC_W-1:0]  func;
    logic [VAR_W-1:0]   var_index;
    logic [CHILD_W-1:0] high_child;
    logic [CHILD_W-1:0] low_child;
    logic [INDEX_W-1:0] node_index;

    modport source (output valid, func, var_index, high_child, low_child, node_index,
                    input ready);
    modport sink   (input valid, func, var_index, high_child, low_child, node_index,
                    output ready);
endinterface

// Response channel of the unique node table: valid, ready and one result item.
interface bunt_rsp_if import bunt_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               found;
    logic [INDEX_W-1:0] match_index;

    modport source (output valid, found, match_index, input ready);
    modport sink   (input valid, found, match_index, output ready);
endinterface

[rtl/core/bdd_unique_node_table_core.sv]
// Channel   Dir  Payload                                              Accepted when
// i_req     in   func, var_index, high_child, low_child, node_index   valid && ready
// o_rsp     out  found, match_index                                   valid && ready
//
// An insert goes from acceptance through states HEAD and DONE to its result register;
// a lookup also walks the chain in WALK, one node memory read per link walked.
// The node memory read port, walked once per cycle, sets the lookup time.
// After reset the bucket heads are cleared by a sweep; no item is taken during it.
// One item is in work at a time; a pending result waits in the output register and
// holds the next result back only while it is still not taken.
// BUCKETS and NODES must be powers of two.
module bdd_unique_node_table_core
    import bunt_pkg::*;
#(
    parameter int BUCKETS = 4096,
    parameter int NODES   = 65536
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    bunt_req_if.sink   i_req,
    bunt_rsp_if.source o_rsp
);

    localparam int BW    = $clog2(BUCKETS);
    localparam int NW    = $clog2(NODES);
    localparam int IXW   = (NW > INDEX_W) ? NW : INDEX_W;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_HEAD = 3'd2;
    localparam logic [2:0] S_WALK = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    typedef struct packed {
        logic               valid;
        logic [NW-1:0]      index;
    } t_link;

    typedef struct packed {
        logic [VAR_W-1:0]   var_index;
        logic [CHILD_W-1:0] high_child;
        logic [CHILD_W-1:0] low_child;
        t_link              next;
    } t_node;

    t_link head_mem [BUCKETS];
    t_node node_mem [NODES];

    logic [2:0]         r_state, n_state;
    logic [BW-1:0]      r_clr_addr;
    logic               r_func;
    logic [VAR_W-1:0]   r_var;
    logic [CHILD_W-1:0] r_high;
    logic [CHILD_W-1:0] r_low;
    logic [NW-1:0]      r_idx;
    logic [BW-1:0]      r_bucket;
    logic [NW-1:0]      r_cur, n_cur;
    logic [NW-1:0]      r_steps, n_steps;
    logic               r_res_found, n_res_found;
    logic [NW-1:0]      r_res_index, n_res_index;
    logic               r_out_valid;
    logic               r_out_found;
    logic [INDEX_W-1:0] r_out_index;

    t_link              r_head_q;
    t_node              r_node_q;

    logic               accept;
    logic [HASH_W-1:0]  hash_sum;
    logic [IXW-1:0]     idx_ext;
    logic [IXW-1:0]     res_ext;
    logic               head_we;
    logic [BW-1:0]      head_wa;
    t_link              head_wd;
    logic               node_we;
    t_node              node_wd;
    logic               node_re;
    logic [NW-1:0]      node_ra;
    logic               node_hit;
    logic               out_free;

    assign accept   = i_req.valid && i_req.ready;
    assign hash_sum = bunt_hash(i_req.var_index, i_req.high_child, i_req.low_child);
    assign idx_ext  = IXW'(i_req.node_index);
    assign res_ext  = IXW'(r_res_index);
    assign out_free = !r_out_valid || o_rsp.ready;

    assign i_req.ready = (r_state == S_IDLE);
    assign node_hit = (r_node_q.high_child == r_high) && (r_node_q.low_child == r_low)
                   && (r_node_q.var_index == r_var);

    // Bucket head memory: cleared by the sweep after reset, written on insert.
    always_comb begin
        head_we = 1'b0;
        head_wa = r_bucket;
        head_wd = '{valid: 1'b1, index: r_idx};
        if (r_state == S_CLR) begin
            head_we = 1'b1;
            head_wa = r_clr_addr;
            head_wd = '0;
        end else if (r_state == S_HEAD && r_func == FUNC_INSERT) begin
            head_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (head_we) begin
            head_mem[head_wa] <= head_wd;
        end
        if (accept) begin
            r_head_q <= head_mem[hash_sum[BW-1:0]];
        end
    end

    // Node memory: written on insert, read once per chain link on lookup.
    assign node_we = (r_state == S_HEAD) && (r_func == FUNC_INSERT);
    assign node_wd = '{var_index: r_var, high_child: r_high, low_child: r_low,
                       next: r_head_q};

    always_comb begin
        node_re = 1'b0;
        node_ra = r_head_q.index;
        if (r_state == S_HEAD && r_func == FUNC_LOOKUP && r_head_q.valid) begin
            node_re = 1'b1;
        end else if (r_state == S_WALK && !node_hit && r_node_q.next.valid
                     && r_steps != NW'(NODES - 1)) begin
            node_re = 1'b1;
            node_ra = r_node_q.next.index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (node_we) begin
            node_mem[r_idx] <= node_wd;
        end
        if (node_re) begin
            r_node_q <= node_mem[node_ra];
        end
    end

    // Sequencer for one item.
    always_comb begin
        n_state     = r_state;
        n_cur       = r_cur;
        n_steps     = r_steps;
        n_res_found = r_res_found;
        n_res_index = r_res_index;
        unique case (r_state)
            S_CLR: begin
                if (r_clr_addr == BW'(BUCKETS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_HEAD;
                end
            end
            S_HEAD: begin
                n_res_found = 1'b0;
                n_res_index = '0;
                n_steps     = '0;
                n_cur       = r_head_q.index;
                if (r_func == FUNC_LOOKUP && r_head_q.valid) begin
                    n_state = S_WALK;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_WALK: begin
                if (node_hit) begin
                    n_res_found = 1'b1;
                    n_res_index = r_cur;
                    n_state     = S_DONE;
                end else if (node_re) begin
                    n_cur   = r_node_q.next.index;
                    n_steps = r_steps + 1'b1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func   <= i_req.func;
            r_var    <= i_req.var_index;
            r_high   <= i_req.high_child;
            r_low    <= i_req.low_child;
            r_idx    <= idx_ext[NW-1:0];
            r_bucket <= hash_sum[BW-1:0];
        end
        r_cur       <= n_cur;
        r_steps     <= n_steps;
        r_res_found <= n_res_found;
        r_res_index <= n_res_index;
        if (r_state == S_DONE && out_free) begin
            r_out_found <= r_res_found;
            r_out_index <= res_ext[INDEX_W-1:0];
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.found       = r_out_found;
    assign o_rsp.match_index = r_out_index;

endmodule

[rtl/core/bunt_checker.sv]
// Port-level checks for the unique node table core, attached by bind.
// Depends on bunt_pkg and on the ports of bdd_unique_node_table_core.
module bunt_checker
    import bunt_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic               i_out_found,
    input logic [INDEX_W-1:0] i_out_index
);

    // The clearing sweep keeps the request side closed right after reset.
    a_no_accept_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("request ready right after reset");

    // Only one item is in work: acceptance closes the request side.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second item accepted while one is in work");

    // A miss or an insert reports index zero.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_found |-> i_out_index == '0)
        else $error("nonzero index on a result that is not found");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_found)
                                        && $stable(i_out_index))
        else $error("stalled result item changed or dropped");

endmodule

bind bdd_unique_node_table_core bunt_checker u_bunt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_out_found (o_rsp.found),
    .i_out_index (o_rsp.match_index)
);
